/* hw/rtl/aes_cfb_pkg.sv */
// ----------------------------------------------------------------------------
// aes_cfb_pkg
// Shared types, tables and round functions of the AES-CFB128 cipher core.
// ----------------------------------------------------------------------------
package aes_cfb_pkg;

	typedef struct packed {
		logic [63:0] text_high;
		logic [63:0] text_low;
		logic [4:0]  byte_count;
		logic        first;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic [4:0]  result_count;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP,
		ST_PRE,
		ST_RUN,
		ST_DONE
	} core_state_t;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_KSIZE = 3'd4;
	localparam logic [2:0] REG_DIR   = 3'd5;
	localparam logic [2:0] REG_IV0   = 3'd6;
	localparam logic [2:0] REG_IV1   = 3'd7;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			4'd12:   r = 8'h01;
			4'd13:   r = 8'h02;
			4'd14:   r = 8'h04;
			4'd15:   r = 8'h08;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// one cipher round; byte 0 sits in the top bits
	function automatic logic [127:0] enc_round(input logic [127:0] st,
			input logic [127:0] rk, input logic last);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] x;
		logic [127:0] o;
		for (int i = 0; i < 16; i++) begin
			s[i] = SBOX[st[127-8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c+r] = s[4*((c+r)%4)+r];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
				s[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
				s[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
				s[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
				s[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
			end
		end else begin
			for (int i = 0; i < 16; i++) begin
				s[i] = t[i];
			end
		end
		for (int i = 0; i < 16; i++) begin
			o[127-8*i -: 8] = s[i];
		end
		return o ^ rk;
	endfunction

endpackage

/* hw/rtl/aes_cfb_ram.sv */
// ----------------------------------------------------------------------------
// aes_cfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aes_cfb_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/aes_cfb_kexp.sv */
// ----------------------------------------------------------------------------
// aes_cfb_kexp
// Key expander: one key word per cycle, one round key row per four words.
// ----------------------------------------------------------------------------
module aes_cfb_kexp import aes_cfb_pkg::*; #(
	parameter int ROUND_KEY_SLOTS = 15,
	localparam int AW = $clog2(ROUND_KEY_SLOTS)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [255:0]   key,
	input  logic [1:0]     sel,
	input  logic [AW-1:0]  nr,
	output logic           busy,
	output logic           we,
	output logic [AW-1:0]  waddr,
	output logic [127:0]   wdata
);
	logic          busy_q;
	logic [AW+1:0] i_q;
	logic [AW+1:0] last_q;
	logic [2:0]    m_q;
	logic [3:0]    rc_q;
	logic [3:0]    nk_q;
	logic [255:0]  key_q;
	logic [31:0]   win_q [8];
	logic [95:0]   row_q;
	logic [31:0]   kw;
	logic [31:0]   t;
	logic [31:0]   wold;

	always_comb begin
		t = win_q[7];
		case (nk_q)
			4'd4:    wold = win_q[4];
			4'd6:    wold = win_q[2];
			default: wold = win_q[0];
		endcase
		if (m_q == 3'd0) begin
			t = sub_word({t[23:0], t[31:24]}) ^ {rcon(rc_q), 24'h0};
		end else if (nk_q == 4'd8 && m_q == 3'd4) begin
			t = sub_word(t);
		end
		if ({{(4 - ((AW+2) < 4 ? (AW+2) : 4)){1'b0}}, i_q[((AW+2) < 4 ? (AW+2) : 4)-1:0]} < nk_q
				&& i_q[AW+1:3] == '0) begin
			kw = key_q[255 - 32*i_q[2:0] -: 32];
		end else begin
			kw = wold ^ t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && i_q == last_q) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q  <= key;
			nk_q   <= 4'(4 + 2 * sel);
			last_q <= (AW+2)'({nr, 2'b11});
			i_q    <= '0;
			m_q    <= '0;
			rc_q   <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if ({1'b0, m_q} == nk_q - 4'd1) begin
				m_q  <= '0;
				rc_q <= rc_q + 4'd1;
			end else begin
				m_q <= m_q + 3'd1;
			end
			for (int j = 0; j < 7; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[7] <= kw;
			case (i_q[1:0])
				2'd0:    row_q[95:64] <= kw;
				2'd1:    row_q[63:32] <= kw;
				default: row_q[31:0]  <= kw;
			endcase
		end
	end

	assign busy  = busy_q;
	assign we    = busy_q && i_q[1:0] == 2'b11;
	assign waddr = i_q[AW+1:2];
	assign wdata = {row_q, kw};
endmodule

/* hw/rtl/aes_cfb128_cipher_core.sv */
// AES-CFB128 cipher core.
// A word runs a key addition, then nr rounds (nr = 10, 12 or 14), one per cycle
// against the round key memory, after key expansion for a first or unkeyed word.
// Throughput: one word at a time, each chained on the previous feedback block.
// Reset: feedback block zero, no keys loaded, key size 128 bit, direction encrypt.
// ----------------------------------------------------------------------------
// aes_cfb128_cipher_core
// Top level: config registers, round sequencer, key expander, round key memory, feedback.
// ----------------------------------------------------------------------------
module aes_cfb128_cipher_core import aes_cfb_pkg::*; #(
	parameter int ROUND_KEY_SLOTS = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);
	localparam int AW = $clog2(ROUND_KEY_SLOTS);
	localparam logic [4:0] MAXR = 5'(ROUND_KEY_SLOTS - 1);

	core_state_t state_q, state_d;

	logic [63:0]   key_q [4];
	logic [63:0]   iv_q [2];
	logic [1:0]    ksize_q;
	logic          dir_q;
	logic [127:0]  fb_q;
	logic          loaded_q;
	logic [AW-1:0] nr_q;
	logic [AW-1:0] rnd_q;
	logic [127:0]  st_q;
	logic [127:0]  data_q;
	logic [4:0]    cnt_q;
	logic          out_valid_q;
	out_word_t     out_q;

	logic          accept;
	logic          need_exp;
	logic [1:0]    sel;
	logic [4:0]    nr_full;
	logic [AW-1:0] nr_new;
	logic          kx_busy;
	logic          kx_we;
	logic [AW-1:0] kx_waddr;
	logic [127:0]  kx_wdata;
	logic [AW-1:0] raddr;
	logic [127:0]  rk;
	logic [127:0]  res;
	logic [127:0]  fb_new;
	logic          out_free;

	assign accept   = in_valid && in_ready;
	assign need_exp = in_word.first || !loaded_q;
	assign sel      = (ksize_q == 2'd3) ? 2'd2 : ksize_q;
	assign nr_full  = 5'(10 + 2 * sel);
	assign nr_new   = AW'((nr_full > MAXR) ? MAXR : nr_full);
	assign out_free = !out_valid_q || out_ready;
	assign raddr    = (state_q == ST_RUN) ? AW'(rnd_q + 1'b1) : '0;

	aes_cfb_kexp #(.ROUND_KEY_SLOTS(ROUND_KEY_SLOTS)) u_kexp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept && need_exp),
		.key   ({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.sel   (sel),
		.nr    (nr_new),
		.busy  (kx_busy),
		.we    (kx_we),
		.waddr (kx_waddr),
		.wdata (kx_wdata)
	);

	aes_cfb_ram #(.WIDTH(128), .DEPTH(ROUND_KEY_SLOTS)) u_rk_ram (
		.clk  (clk),
		.we   (kx_we),
		.waddr(kx_waddr),
		.wdata(kx_wdata),
		.raddr(raddr),
		.rdata(rk)
	);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < cnt_q) begin
				res[127-8*i -: 8]    = data_q[127-8*i -: 8] ^ st_q[127-8*i -: 8];
				fb_new[127-8*i -: 8] = dir_q ? res[127-8*i -: 8] : data_q[127-8*i -: 8];
			end else begin
				res[127-8*i -: 8]    = 8'h00;
				fb_new[127-8*i -: 8] = fb_q[127-8*i -: 8];
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = need_exp ? ST_EXP : ST_RUN;
				end
			end
			ST_EXP: begin
				if (!kx_busy) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE: state_d = ST_RUN;
			ST_RUN: begin
				if (rnd_q == nr_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= '{default: '0};
			iv_q        <= '{default: '0};
			ksize_q     <= 2'd0;
			dir_q       <= 1'b1;
			fb_q        <= '0;
			loaded_q    <= 1'b0;
			nr_q        <= AW'((5'd10 > MAXR) ? MAXR : 5'd10);
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_KEY0:  key_q[0] <= cfg_data;
					REG_KEY1:  key_q[1] <= cfg_data;
					REG_KEY2:  key_q[2] <= cfg_data;
					REG_KEY3:  key_q[3] <= cfg_data;
					REG_KSIZE: ksize_q  <= cfg_data[1:0];
					REG_DIR:   dir_q    <= cfg_data[0];
					REG_IV0:   iv_q[0]  <= cfg_data;
					REG_IV1:   iv_q[1]  <= cfg_data;
					default:   ;
				endcase
			end
			if (accept && need_exp) begin
				fb_q     <= {iv_q[0], iv_q[1]};
				loaded_q <= 1'b1;
				nr_q     <= nr_new;
			end
			if (state_q == ST_RUN) begin
				rnd_q <= (rnd_q == nr_q) ? '0 : AW'(rnd_q + 1'b1);
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				fb_q        <= fb_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {in_word.text_high, in_word.text_low};
			cnt_q  <= (in_word.byte_count > 5'd16) ? 5'd16 : in_word.byte_count;
		end
		if (state_q == ST_RUN) begin
			st_q <= (rnd_q == '0) ? (fb_q ^ rk) : enc_round(st_q, rk, rnd_q == nr_q);
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= '{result_high: res[127:64], result_low: res[63:0], result_count: cnt_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_no_kx_outside_exp: assert property (@(posedge clk) disable iff (!arst_n)
		kx_busy |-> (state_q == ST_EXP || $past(accept)))
		else $error("key expansion active outside expansion state");

	a_no_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_PRE) |-> !kx_we)
		else $error("round key write during cipher rounds");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> rnd_q <= nr_q)
		else $error("round counter past round count");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> out_valid)
		else $error("finished word not presented");
endmodule
